// ===== src/positional_list_insert_delete_defines.svh =====
// Assertion macros for the positional list top level.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define PLID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("positional list check failed");
// Check a property on every edge, reset included.
`define PLID_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("positional list reset check failed");
`else
`define PLID_ASSERT(lbl, prop)
`define PLID_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/plid_pkg.sv =====
// Types and codes for the positional list.
package plid_pkg;

    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [DATA_W-1:0] read_value;
    } out_item_t;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== src/plid_cell.sv =====
// One list cell: holds one entry and shifts with its neighbors.
module plid_cell #(
    parameter int INDEX = 0,
    parameter int TW    = 6
) (
    input  logic                              aclk,
    input  plid_pkg::cell_cmd_t               cmd,
    input  logic [TW-1:0]                     target,
    input  logic signed [plid_pkg::DATA_W-1:0] left_data,
    input  logic signed [plid_pkg::DATA_W-1:0] right_data,
    output logic signed [plid_pkg::DATA_W-1:0] q
);
    import plid_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // Take from the lower neighbor on insert, from the upper one on delete.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (INDEX > int'(target)) begin
                entry_next = left_data;
            end else if (INDEX == int'(target)) begin
                entry_next = cmd.value;
            end
        end else if (cmd.del) begin
            if (INDEX >= int'(target)) begin
                entry_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== src/positional_list_insert_delete.sv =====
// Positional list top level: control, count, cell chain and result register.
// The result of an item is registered when the item transfers and shown in the next cycle.
// Throughput: one item per cycle while results are taken; every cell shifts in parallel.
// A stalled result holds the input off until it is taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending result;
// entry contents are not cleared and are never read before being written.
`include "positional_list_insert_delete_defines.svh"
module positional_list_insert_delete #(
    parameter int DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plid_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output plid_pkg::out_item_t m_item
);
    import plid_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic                     accept;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     m_valid_reg;
    out_item_t                out_reg;
    logic [CMPW-1:0]          pos_w;
    logic [CMPW-1:0]          cnt_w;
    logic [CMPW-1:0]          pos_m1;
    logic [CMPW-1:0]          target;
    logic [IW-1:0]            rd_idx;
    logic                     do_ins;
    logic                     do_del;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] rd_value;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] q_arr [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_w  = CMPW'(s_item.position);
    assign cnt_w  = CMPW'(count_reg);
    assign pos_m1 = pos_w - CMPW'(1);
    assign rd_idx = pos_m1[IW-1:0];

    // Decode the operation and check its range and, for an insert, a full list.
    always_comb begin
        status     = ST_DONE;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        rd_value   = '0;
        count_next = count_reg;
        target     = pos_w;
        unique case (s_item.kind)
            KIND_INSERT: begin
                if (pos_w > cnt_w) begin
                    status = ST_RANGE;
                end else if (cnt_w >= CMPW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_DELETE: begin
                target = pos_m1;
                if (pos_w == '0 || pos_w > cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    do_del     = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_READ: begin
                if (pos_w == '0 || pos_w > cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    rd_value = q_arr[rd_idx];
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    assign cmd.ins   = accept && do_ins;
    assign cmd.del   = accept && do_del;
    assign cmd.value = s_item.value;

    // Build the cell chain; the ends take zero from outside.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;
        if (i == 0) begin : g_head
            assign left_d = '0;
        end else begin : g_body_l
            assign left_d = q_arr[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_body_r
            assign right_d = q_arr[i+1];
        end
        plid_cell #(
            .INDEX (i),
            .TW    (CMPW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .target     (target),
            .left_data  (left_d),
            .right_data (right_d),
            .q          (q_arr[i])
        );
    end

    // Advance the count and hold the result until transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg.status      <= status;
            out_reg.entry_count <= COUNT_W'(count_next);
            out_reg.read_value  <= rd_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    `PLID_ASSERT(a_count_bound, count_reg <= CW'(DEPTH))
    `PLID_ASSERT(a_clear_empties, (accept && s_item.kind == KIND_CLEAR) |=> count_reg == '0)
    `PLID_ASSERT(a_insert_grows, cmd.ins |=> count_reg == $past(count_reg) + CW'(1))
    `PLID_ASSERT(a_stall_cause, !s_ready |-> m_valid_reg)
    `PLID_ASSERT(a_full_count, (m_valid_reg && out_reg.status == ST_FULL) |-> count_reg == CW'(DEPTH))
    `PLID_ASSERT_RST(a_reset_state, !aresetn |=> (count_reg == '0 && !m_valid_reg))

endmodule

// ===== tb/positional_list_insert_delete_test.sv =====
// Self-checking testbench for the positional list: random and directed list operations.
module positional_list_insert_delete_test;
    import plid_pkg::*;

    localparam int LIST_DEPTH    = 32;
    localparam int HOLD_CYCLES   = 200;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int CHUNK_ITEMS   = 85;
    localparam int CHUNKS_PHASE  = 5;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Stimulus waiting to be offered, expected results in order, and the list mirror
    in_item_t                 pending_ops[$];
    out_item_t                results_due[$];
    logic signed [DATA_W-1:0] list_vals[$];

    int planned_count = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int errors        = 0;
    int items_in      = 0;
    int results_out   = 0;
    int kind_seen[4]  = '{default: 0};
    int status_seen[3] = '{default: 0};
    int peak_count    = 0;

    always #6 aclk = ~aclk;

    positional_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    // Apply one operation to the list mirror and return the result it yields
    function automatic out_item_t apply_list_op(input in_item_t op);
        out_item_t res;
        int        cnt;
        int        pos;
        res = '0;
        res.status = ST_DONE;
        cnt = list_vals.size();
        pos = int'(op.position);
        case (op.kind)
            KIND_INSERT: begin
                if (pos > cnt)
                    res.status = ST_RANGE;
                else if (cnt >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                    list_vals.insert(pos, op.value);
            end
            KIND_DELETE: begin
                if (pos == 0 || pos > cnt)
                    res.status = ST_RANGE;
                else
                    list_vals.delete(pos - 1);
            end
            KIND_READ: begin
                if (pos == 0 || pos > cnt)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_vals[pos - 1];
            end
            default: begin
                list_vals.delete();
            end
        endcase
        res.entry_count = COUNT_W'(list_vals.size());
        return res;
    endfunction

    // Drive the input channel: advance to the next item once the current one transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_item  <= pending_ops.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Watch both channels: predict on input transfers, check output transfers, drive ready
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = apply_list_op(s_item);
                results_due.push_back(want);
                items_in++;
                kind_seen[s_item.kind]++;
                status_seen[want.status]++;
                if (list_vals.size() > peak_count)
                    peak_count = list_vals.size();
            end
            if (m_valid && m_ready) begin
                results_out++;
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_item.status);
                        errors++;
                    end
                    if (m_item.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_item.entry_count);
                        errors++;
                    end
                    if (m_item.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, m_item.read_value);
                        errors++;
                    end
                end
            end

            // Stop the run when nothing moves for too long
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_MAX);
                $display("positional_list_insert_delete_test: errors");
                $finish;
            end

            // Hold ready low for a long stretch on request, else stall at random
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end else begin
            m_ready <= 1'b0;
        end
    end

    // Queue one operation and track the count it will leave behind
    task automatic queue_op(input logic [1:0] kind, input int pos,
                            input logic signed [DATA_W-1:0] val);
        in_item_t op;
        op.kind     = kind;
        op.position = pos[POS_W-1:0];
        op.value    = val;
        pending_ops.push_back(op);
        case (kind)
            KIND_INSERT: begin
                if (int'(op.position) <= planned_count && planned_count < LIST_DEPTH)
                    planned_count++;
            end
            KIND_DELETE: begin
                if (op.position != 0 && int'(op.position) <= planned_count)
                    planned_count--;
            end
            KIND_CLEAR: begin
                planned_count = 0;
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed operations, biased to grow or shrink the list, with some noise
    task automatic queue_random_chunk(input int n, input int ins_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                queue_op(2'($urandom_range(0, 3)), $urandom_range(0, 63), pick_value());
            end else if (r < 5) begin
                queue_op(KIND_CLEAR, $urandom_range(0, 63), pick_value());
            end else begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    queue_op(KIND_INSERT, $urandom_range(0, planned_count), pick_value());
                else if (r < ins_pct + (100 - ins_pct) / 2)
                    queue_op(KIND_DELETE, $urandom_range(1, planned_count), pick_value());
                else
                    queue_op(KIND_READ, $urandom_range(1, planned_count), pick_value());
            end
        end
    endtask

    // Wait until every queued item is sent and every expected result has come back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_ops.size() != 0 || s_valid || results_due.size() != 0);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty list edge cases
        queue_op(KIND_READ,   1, 0);
        queue_op(KIND_DELETE, 1, 0);
        queue_op(KIND_INSERT, 1, 32'sh1234_5678);
        queue_op(KIND_CLEAR,  0, 0);
        // Build a short list through head, tail and middle inserts
        queue_op(KIND_INSERT, 0, 32'sh8000_0000);
        queue_op(KIND_INSERT, 1, 32'sh7fff_ffff);
        queue_op(KIND_INSERT, 0, -32'sd1);
        queue_op(KIND_INSERT, 1, 0);
        queue_op(KIND_READ,   1, 0);
        queue_op(KIND_READ,   4, 0);
        // Out of range positions on a non-empty list
        queue_op(KIND_READ,   0, 0);
        queue_op(KIND_READ,   5, 0);
        queue_op(KIND_READ,   63, 0);
        queue_op(KIND_INSERT, 5, 32'sh0f0f_0f0f);
        queue_op(KIND_INSERT, 63, 32'sh5555_5555);
        queue_op(KIND_DELETE, 0, 0);
        queue_op(KIND_DELETE, 5, 0);
        // Delete from middle, head and tail
        queue_op(KIND_DELETE, 2, 0);
        queue_op(KIND_DELETE, 1, 0);
        queue_op(KIND_DELETE, 2, 0);
        queue_op(KIND_READ,   1, 0);
        queue_op(KIND_INSERT, 1, 32'shaaaa_aaaa);
        queue_op(KIND_CLEAR,  0, 0);
        queue_op(KIND_READ,   1, 0);
        wait_drained();

        // Fill to capacity, then hit the full list and out of range on a full list
        for (int i = 0; i < LIST_DEPTH; i++)
            queue_op(KIND_INSERT, $urandom_range(0, planned_count), pick_value());
        queue_op(KIND_INSERT, LIST_DEPTH, pick_value());
        queue_op(KIND_INSERT, 0, pick_value());
        queue_op(KIND_INSERT, LIST_DEPTH + 1, pick_value());
        queue_op(KIND_READ,   LIST_DEPTH, 0);
        queue_op(KIND_DELETE, LIST_DEPTH, 0);
        queue_op(KIND_READ,   1, 0);
        wait_drained();

        // Random phases: no idling but one long ready hold, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            tx_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 31 : 0;
            rx_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 31 : 0;
            if (phase == 0)
                hold_requests++;
            for (int c = 0; c < CHUNKS_PHASE; c++)
                queue_random_chunk(CHUNK_ITEMS, (c % 2 == 0) ? 70 : 25);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            errors++;
        end
        $display("Ran %0d operations (%0d insert, %0d delete, %0d read, %0d clear), %0d results",
                 items_in, kind_seen[KIND_INSERT], kind_seen[KIND_DELETE],
                 kind_seen[KIND_READ], kind_seen[KIND_CLEAR], results_out);
        $display("Statuses: %0d done, %0d out of range, %0d full; list peaked at %0d entries",
                 status_seen[ST_DONE], status_seen[ST_RANGE], status_seen[ST_FULL],
                 peak_count);
        if (errors == 0) begin
            $display("positional_list_insert_delete_test: clean");
        end else begin
            $display("positional_list_insert_delete_test: errors");
        end
        $finish;
    end

endmodule

// ===== positional_list_insert_delete.f =====
+incdir+src
src/plid_pkg.sv
src/plid_cell.sv
src/positional_list_insert_delete.sv
tb/positional_list_insert_delete_test.sv
